[hw/rtl/tsps_pkg.sv]
`default_nettype none
package tsps_pkg;
    localparam int SLOTS_DEF  = 16;
    localparam int GROUPS_DEF = 4;
    localparam int FUNC_W = 3;
    localparam int PRIO_W = 32;
    localparam int GID_W  = 2;
    localparam int SID_W  = 4;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 5;
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        F_CREATE = 3'd0, F_PICK = 3'd1, F_RESUME_ID = 3'd2, F_YIELD = 3'd3,
        F_FINISH = 3'd4, F_GROUP_OPEN = 3'd5, F_GROUP_PARK = 3'd6,
        F_RESUME_DONE = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NOTRUN = 3'd1, ST_NOSLOT = 3'd2, ST_NOGROUP = 3'd3,
        ST_PENDING = 3'd4, ST_BADGROUP = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        M_IDLE = 2'd0, M_READY = 2'd1, M_RUN = 2'd2, M_SUSP = 2'd3
    } t_mode;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PRIO_W-1:0] priority_req;
        logic              group_valid;
        logic [GID_W-1:0]  group_id;
        logic [SID_W-1:0]  slot_id;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SID_W-1:0]  slot_out;
        logic [GID_W-1:0]  group_out;
        logic              any_idle;
        logic              any_busy;
        logic [CNT_W-1:0]  active_tasks;
    } t_res;
endpackage
`default_nettype wire

[hw/rtl/tsps_if.sv]
`default_nettype none
interface tsps_cmd_if;
    logic valid;
    logic ready;
    tsps_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsps_res_if;
    logic valid;
    logic ready;
    tsps_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/tsps_front.sv]
`default_nettype none
// accepts transactions into a short queue for the scheduling engine
module tsps_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    tsps_cmd_if.sink        i_cmd,
    output tsps_pkg::t_cmd  o_cmd,
    output logic            o_valid,
    input  wire             i_take
);
    import tsps_pkg::*;
    t_cmd       r_q [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    logic       push, pop;

    assign i_cmd.ready = (r_fill != 2'(QDEPTH));
    assign push = i_cmd.valid && i_cmd.ready;
    assign pop  = i_take && o_valid;
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_cmd.data;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_fill <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_fill <= r_fill + 2'(push) - 2'(pop);
        end
    end

`ifndef SYNTHESIS
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'(QDEPTH)) else $error("queue overfilled");
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd0) |-> !pop) else $error("pop from empty queue");
    a_full_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_fill == $past(r_fill) + 2'd1)) else $error("fill slip");
`endif
endmodule
`default_nettype wire

[hw/rtl/tsps_back.sv]
`default_nettype none
// scheduling engine: slot search over cycles, then one update, then result
module tsps_back #(
    parameter int SLOTS  = tsps_pkg::SLOTS_DEF,
    parameter int GROUPS = tsps_pkg::GROUPS_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_we,
    input  wire [4:0]       i_cfg_data,
    input  wire tsps_pkg::t_cmd i_cmd,
    input  wire             i_valid,
    output logic            o_take,
    tsps_res_if.source      o_res
);
    import tsps_pkg::*;
    localparam int SW = $clog2(SLOTS);
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int NW = $clog2(SLOTS + 1);
    localparam int QW = $clog2(GROUPS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_EXEC = 4'b0100, S_OUT = 4'b1000
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [4:0] r_cnt_cfg;
    logic [1:0]        r_mode [SLOTS];
    logic [PRIO_W-1:0] r_prio [SLOTS];
    logic [GW-1:0]     r_sgrp [SLOTS];
    logic [SLOTS-1:0]  r_linked, r_parked;
    logic [1:0]        r_gmode [GROUPS];
    logic [SW-1:0]     r_gown [GROUPS];
    logic [SLOTS-1:0]  r_gmem [GROUPS], r_gfin [GROUPS];
    logic [SW-1:0]     r_run;
    logic              r_runv;
    logic [CNT_W-1:0]  r_tasks;
    logic [SW-1:0]     r_dq [GROUPS];
    logic [QW-1:0]     r_dqn;
    // scan results
    logic [SW-1:0]     r_idx;
    logic [SW-1:0]     r_best;
    logic [PRIO_W-1:0] r_bprio;
    logic              r_bfound, r_bpark, r_pend;
    logic [SW-1:0]     r_free;
    logic              r_freev;
    t_res              r_res;
    logic              r_ovalid;

    // used slot count, clamped
    logic [NW-1:0] used_n;
    always_comb begin
        if (r_cnt_cfg == 5'd0) used_n = NW'(1);
        else if (32'(r_cnt_cfg) > SLOTS) used_n = NW'(SLOTS);
        else used_n = NW'(r_cnt_cfg);
    end

    // per slot: ready to run when a parked owner's group is done
    logic [SLOTS-1:0] s_ready;
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            s_ready[s] = 1'b0;
            for (int g = 0; g < GROUPS; g++)
                if (r_gmode[g] == M_RUN && r_gown[g] == SW'(s) &&
                    (r_gmem[g] & ~r_gfin[g]) == '0)
                    s_ready[s] = 1'b1;
        end
    end

    // groups owned by running task, lowest idle group, running group owned by best slot
    logic [GROUPS-1:0] own_open;
    logic [GW-1:0] open_g, idle_g, park_g;
    logic open_hit, idle_hit, park_hit;
    always_comb begin
        open_hit = 1'b0; idle_hit = 1'b0; park_hit = 1'b0;
        open_g = '0; idle_g = '0; park_g = '0;
        for (int g = GROUPS-1; g >= 0; g--) begin
            own_open[g] = r_gmode[g] == M_READY && r_gown[g] == r_run;
            if (own_open[g]) begin open_hit = 1'b1; open_g = GW'(g); end
            if (r_gmode[g] == M_IDLE) begin idle_hit = 1'b1; idle_g = GW'(g); end
        end
        for (int g = GROUPS-1; g >= 0; g--)
            if (r_gmode[g] == M_RUN && r_gown[g] == r_best) begin
                park_hit = 1'b1; park_g = GW'(g);
            end
    end

    logic [SW-1:0] cur;
    logic cur_runnable, cur_pk;
    assign cur = r_idx;
    assign cur_runnable = (r_mode[cur] == M_READY || r_mode[cur] == M_SUSP) &&
                          !(r_parked[cur] && !s_ready[cur]);
    assign cur_pk = r_parked[cur];

    logic id_ok_g;
    assign id_ok_g = (32'(r_cmd.group_id) < GROUPS);
    logic [GW-1:0] gid;
    assign gid = GW'(r_cmd.group_id);
    logic gid_own_open;
    assign gid_own_open = id_ok_g && r_gmode[gid] == M_READY && r_gown[gid] == r_run;

    assign o_take = (r_state == S_IDLE) && i_valid;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_res;

    // flags after the update
    logic f_idle, f_busy;
    always_comb begin
        f_idle = 1'b0; f_busy = r_runv;
        for (int s = 0; s < SLOTS; s++)
            if (NW'(s) < used_n) begin
                if (r_mode[s] == M_IDLE) f_idle = 1'b1;
                else f_busy = 1'b1;
            end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0; r_cnt_cfg <= 5'd16;
            r_runv <= 1'b0; r_run <= '0; r_tasks <= '0; r_dqn <= '0;
            r_linked <= '0; r_parked <= '0;
            for (int s = 0; s < SLOTS; s++) r_mode[s] <= M_IDLE;
            for (int g = 0; g < GROUPS; g++) begin
                r_gmode[g] <= M_IDLE; r_gmem[g] <= '0; r_gfin[g] <= '0;
            end
        end else begin
            if (i_cfg_we) r_cnt_cfg <= i_cfg_data;
            if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd; r_idx <= '0; r_bfound <= 1'b0;
                        r_pend <= 1'b0; r_freev <= 1'b0; r_bpark <= 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                // one slot per cycle: lowest idle and best pick candidate; resume events skip the scan
                S_SCAN: begin
                    if (r_cmd.func == F_RESUME_ID) begin
                        r_best <= SW'(r_cmd.slot_id);
                        r_state <= S_EXEC;
                    end else if (r_cmd.func == F_RESUME_DONE) begin
                        r_best <= r_dq[0];
                        r_state <= S_EXEC;
                    end else begin
                        if (NW'(cur) < used_n) begin
                            if (r_mode[cur] == M_IDLE && !r_freev) begin
                                r_freev <= 1'b1; r_free <= cur;
                            end
                            if ((r_mode[cur] == M_READY || r_mode[cur] == M_SUSP) &&
                                cur_pk && !s_ready[cur]) r_pend <= 1'b1;
                            if (cur_runnable && (!r_bfound || (r_bpark && !cur_pk) ||
                                (r_bpark == cur_pk && r_prio[cur] < r_bprio))) begin
                                r_bfound <= 1'b1; r_best <= cur;
                                r_bprio <= r_prio[cur]; r_bpark <= cur_pk;
                            end
                        end
                        if (32'(cur) == SLOTS-1 || NW'(cur) + NW'(1) >= used_n)
                            r_state <= S_EXEC;
                        else r_idx <= cur + SW'(1);
                    end
                end
                S_EXEC: begin
                    if (!r_ovalid) begin
                        logic [STAT_W-1:0] st;
                        logic [SID_W-1:0]  so;
                        logic [GID_W-1:0]  go;
                        logic              start;
                        logic              rmq;
                        logic [SW-1:0]     j;
                        st = ST_OK; so = '0; go = '0; start = 1'b0; rmq = 1'b0;
                        j = '0;
                        case (t_func'(r_cmd.func))
                            F_CREATE: begin
                                if (r_cmd.group_valid && !(gid_own_open && r_runv))
                                    st = ST_BADGROUP;
                                else if (!r_freev) st = ST_NOSLOT;
                                else begin
                                    r_mode[r_free] <= M_READY;
                                    r_prio[r_free] <= r_cmd.priority_req;
                                    r_linked[r_free] <= r_cmd.group_valid;
                                    r_sgrp[r_free] <= r_cmd.group_valid ? gid : '0;
                                    r_parked[r_free] <= 1'b0;
                                    if (r_cmd.group_valid) begin
                                        r_gmem[gid][r_free] <= 1'b1;
                                        r_gfin[gid][r_free] <= 1'b0;
                                    end
                                    r_tasks <= r_tasks + CNT_W'(1);
                                    so = SID_W'(r_free);
                                end
                            end
                            F_PICK: begin
                                if (r_runv) st = ST_NOTRUN;
                                else if (!r_bfound) st = r_pend ? ST_PENDING : ST_NOTRUN;
                                else begin start = 1'b1; so = SID_W'(r_best); end
                            end
                            F_RESUME_ID: begin
                                if (r_runv || 32'(r_cmd.slot_id) >= 32'(used_n) ||
                                    (r_mode[r_best] != M_READY &&
                                     r_mode[r_best] != M_SUSP)) st = ST_NOTRUN;
                                else if (r_parked[r_best] && !s_ready[r_best])
                                    st = ST_PENDING;
                                else begin start = 1'b1; so = SID_W'(r_best); end
                            end
                            F_YIELD: begin
                                if (!r_runv) st = ST_NOTRUN;
                                else begin
                                    r_mode[r_run] <= M_SUSP; r_runv <= 1'b0;
                                    so = SID_W'(r_run);
                                end
                            end
                            F_FINISH: begin
                                if (!r_runv) st = ST_NOTRUN;
                                else begin
                                    logic [SLOTS-1:0] lk;
                                    lk = r_linked;
                                    if (open_hit) begin
                                        lk = lk & ~r_gmem[open_g];
                                        r_gmode[open_g] <= M_IDLE;
                                        r_gmem[open_g] <= '0;
                                        r_gfin[open_g] <= '0;
                                    end
                                    if (lk[r_run]) begin
                                        j = r_gown[r_sgrp[r_run]];
                                        if (!(open_hit && open_g == r_sgrp[r_run])) begin
                                            r_gfin[r_sgrp[r_run]][r_run] <= 1'b1;
                                            if (r_gmode[r_sgrp[r_run]] == M_RUN &&
                                                (r_gmem[r_sgrp[r_run]] &
                                                 ~(r_gfin[r_sgrp[r_run]] |
                                                   (SLOTS'(1) << r_run))) == '0 &&
                                                32'(r_dqn) < GROUPS) begin
                                                r_dq[GW'(r_dqn)] <= j;
                                                r_dqn <= r_dqn + QW'(1);
                                            end
                                        end
                                    end
                                    lk[r_run] = 1'b0;
                                    r_linked <= lk;
                                    r_mode[r_run] <= M_IDLE;
                                    r_parked[r_run] <= 1'b0;
                                    if (r_tasks != '0) r_tasks <= r_tasks - CNT_W'(1);
                                    r_runv <= 1'b0;
                                    so = SID_W'(r_run);
                                end
                            end
                            F_GROUP_OPEN: begin
                                if (!r_runv) st = ST_NOTRUN;
                                else if (open_hit) st = ST_BADGROUP;
                                else if (!idle_hit) st = ST_NOGROUP;
                                else begin
                                    r_gmode[idle_g] <= M_READY;
                                    r_gown[idle_g] <= r_run;
                                    r_gmem[idle_g] <= '0; r_gfin[idle_g] <= '0;
                                    go = GID_W'(idle_g);
                                end
                            end
                            F_GROUP_PARK: begin
                                if (!r_runv) st = ST_NOTRUN;
                                else if (!gid_own_open) st = ST_BADGROUP;
                                else begin
                                    r_gmode[gid] <= M_RUN;
                                    r_mode[r_run] <= M_SUSP;
                                    r_parked[r_run] <= 1'b1;
                                    r_runv <= 1'b0;
                                    if ((r_gmem[gid] & ~r_gfin[gid]) == '0 &&
                                        32'(r_dqn) < GROUPS) begin
                                        r_dq[GW'(r_dqn)] <= r_run;
                                        r_dqn <= r_dqn + QW'(1);
                                    end
                                    so = SID_W'(r_run);
                                end
                            end
                            default: begin
                                if (r_runv || r_dqn == '0) st = ST_NOTRUN;
                                else if (r_mode[r_best] != M_SUSP || !r_parked[r_best] ||
                                         !s_ready[r_best]) begin
                                    st = ST_NOTRUN; rmq = 1'b1;
                                end else begin start = 1'b1; so = SID_W'(r_best); end
                            end
                        endcase
                        if (start) begin
                            if (r_parked[r_best]) begin
                                if (park_hit) begin
                                    r_gmode[park_g] <= M_IDLE;
                                    r_gmem[park_g] <= '0; r_gfin[park_g] <= '0;
                                end
                                r_parked[r_best] <= 1'b0;
                                rmq = 1'b1;
                            end
                            r_mode[r_best] <= M_RUN;
                            r_run <= r_best; r_runv <= 1'b1;
                        end
                        // remove all queue entries equal to r_best
                        if (rmq) begin
                            logic [QW-1:0] k;
                            k = '0;
                            for (int q = 0; q < GROUPS; q++)
                                if (QW'(q) < r_dqn && r_dq[q] != r_best) begin
                                    r_dq[GW'(k)] <= r_dq[q];
                                    k = k + QW'(1);
                                end
                            r_dqn <= k;
                        end
                        r_res.status <= st; r_res.slot_out <= so; r_res.group_out <= go;
                        // a task running before the event counts as busy
                        r_res.any_busy <= r_runv;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_res.any_idle <= f_idle;
                    r_res.any_busy <= r_res.any_busy | f_busy;
                    r_res.active_tasks <= r_tasks;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> (r_state == S_SCAN)) else $error("take without scan");
    a_tasks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_tasks) <= SLOTS) else $error("task count overflow");
    a_dq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_dqn) <= GROUPS) else $error("done queue overflow");
`endif
endmodule
`default_nettype wire

[hw/rtl/task_slot_priority_scheduler_unit.sv]
// task slot priority scheduler
// i_cmd: one scheduling event per transaction (func, priority_req, group_valid,
//   group_id, slot_id), valid/ready handshake
// o_res: exactly one result per event (status, slot_out, group_out, any_idle,
//   any_busy, active_tasks), valid/ready handshake
// i_cfg_we / i_cfg_data: slot_count register, write only while idle
// a two-entry queue holds events while the engine works
// an input transaction enters the queue and is taken into the engine; the
//   scan then visits each used slot, and an update step and a flag step
//   register the result; resume events pass the scan state without
//   visiting slots
// the engine works on one event at a time; the queue takes new events meanwhile
// reset: all slots and groups idle, no running task, slot_count 16
// a stalled result holds the engine before its update; the input queue then
//   fills and drops ready
`default_nettype none
module task_slot_priority_scheduler_unit #(
    parameter int SLOTS  = tsps_pkg::SLOTS_DEF,
    parameter int GROUPS = tsps_pkg::GROUPS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [4:0]  i_cfg_data,
    tsps_cmd_if.sink   i_cmd,
    tsps_res_if.source o_res
);
    import tsps_pkg::*;
    t_cmd q_cmd;
    logic q_valid, take;

    tsps_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd),
        .o_cmd(q_cmd), .o_valid(q_valid), .i_take(take)
    );

    tsps_back #(.SLOTS(SLOTS), .GROUPS(GROUPS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_cmd(q_cmd), .i_valid(q_valid),
        .o_take(take), .o_res(o_res)
    );
endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
module tb;
    import tsps_pkg::*;

    localparam int NSLOT     = 16;
    localparam int NGROUP    = 4;
    localparam int WDOG_MAX  = 4000;
    localparam int SETTLE    = 40;
    localparam int HOLD_LEN  = 300;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_data;

    tsps_cmd_if cmd_if ();
    tsps_res_if res_if ();

    task_slot_priority_scheduler_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    // scheduler shadow state
    t_mode       sh_slot_mode [NSLOT];
    logic [31:0] sh_slot_prio [NSLOT];
    logic [1:0]  sh_slot_grp [NSLOT];
    bit          sh_slot_linked [NSLOT];
    bit          sh_slot_parked [NSLOT];
    t_mode       sh_grp_mode [NGROUP];
    logic [3:0]  sh_grp_owner [NGROUP];
    logic [15:0] sh_grp_members [NGROUP];
    logic [15:0] sh_grp_finished [NGROUP];
    logic [3:0]  sh_run_slot;
    bit          sh_run_valid;
    int          sh_task_cnt;
    logic [3:0]  sh_done_q [NGROUP];
    int          sh_done_fill;
    logic [4:0]  sh_slot_cfg;

    t_res pending_results[$];
    int   errors;
    int   events_sent;
    int   results_seen;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_left = 0;
    bit   hold_start = 1'b0;
    int   quiet_cycles;

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int owned_grp(input logic [3:0] s, input t_mode m);
        for (int g = 0; g < NGROUP; g++)
            if (sh_grp_mode[g] == m && sh_grp_owner[g] == s) return g;
        return NGROUP;
    endfunction

    function automatic bit grp_is_done(input int g);
        return sh_grp_mode[g] == M_RUN && (sh_grp_members[g] & ~sh_grp_finished[g]) == 16'd0;
    endfunction

    function automatic bit parked_can_go(input logic [3:0] s);
        int g;
        g = owned_grp(s, M_RUN);
        return g < NGROUP && grp_is_done(g);
    endfunction

    function automatic void done_q_push(input logic [3:0] s);
        if (sh_done_fill < NGROUP) begin
            sh_done_q[sh_done_fill] = s;
            sh_done_fill++;
        end
    endfunction

    function automatic void done_q_drop(input logic [3:0] s);
        int j;
        j = 0;
        for (int i = 0; i < sh_done_fill; i++)
            if (sh_done_q[i] != s) begin
                sh_done_q[j] = sh_done_q[i];
                j++;
            end
        sh_done_fill = j;
    endfunction

    function automatic void launch_task(input logic [3:0] s);
        int g;
        if (sh_slot_parked[s]) begin
            g = owned_grp(s, M_RUN);
            if (g < NGROUP) begin
                sh_grp_mode[g] = M_IDLE;
                sh_grp_members[g] = '0;
                sh_grp_finished[g] = '0;
            end
            sh_slot_parked[s] = 0;
            done_q_drop(s);
        end
        sh_slot_mode[s] = M_RUN;
        sh_run_slot = s;
        sh_run_valid = 1;
    endfunction

    function automatic void shadow_reset();
        sh_slot_cfg = 5'd16;
        for (int i = 0; i < NSLOT; i++) begin
            sh_slot_mode[i] = M_IDLE;
            sh_slot_prio[i] = '0;
            sh_slot_grp[i] = '0;
            sh_slot_linked[i] = 0;
            sh_slot_parked[i] = 0;
        end
        for (int g = 0; g < NGROUP; g++) begin
            sh_grp_mode[g] = M_IDLE;
            sh_grp_owner[g] = '0;
            sh_grp_members[g] = '0;
            sh_grp_finished[g] = '0;
            sh_done_q[g] = '0;
        end
        sh_run_slot = '0;
        sh_run_valid = 0;
        sh_task_cnt = 0;
        sh_done_fill = 0;
    endfunction

    // apply one event to the shadow state and return the outcome
    function automatic t_res schedule_event(input t_cmd c);
        t_res r;
        int n, i, g, best;
        logic [31:0] bprio;
        bit bpark, pend, pk;
        logic [3:0] rs, q0;
        r = '0;
        r.status = ST_OK;
        // a task running before the event counts as busy
        r.any_busy = sh_run_valid;
        n = (sh_slot_cfg < 1) ? 1 : (sh_slot_cfg > NSLOT) ? NSLOT : int'(sh_slot_cfg);
        rs = sh_run_slot;
        case (t_func'(c.func))
            F_CREATE: begin
                if (c.group_valid && (sh_grp_mode[c.group_id] != M_READY || !sh_run_valid ||
                        sh_grp_owner[c.group_id] != rs)) begin
                    r.status = ST_BADGROUP;
                end else begin
                    for (i = 0; i < n && sh_slot_mode[i] != M_IDLE; i++) ;
                    if (i >= n) r.status = ST_NOSLOT;
                    else begin
                        sh_slot_mode[i] = M_READY;
                        sh_slot_prio[i] = c.priority_req;
                        sh_slot_linked[i] = c.group_valid;
                        sh_slot_grp[i] = c.group_valid ? c.group_id : 2'd0;
                        sh_slot_parked[i] = 0;
                        if (c.group_valid) begin
                            sh_grp_members[c.group_id][i] = 1'b1;
                            sh_grp_finished[c.group_id][i] = 1'b0;
                        end
                        sh_task_cnt++;
                        r.slot_out = i[3:0];
                    end
                end
            end
            F_PICK: begin
                best = NSLOT;
                bprio = '0;
                bpark = 1;
                pend = 0;
                if (sh_run_valid) r.status = ST_NOTRUN;
                else begin
                    for (i = 0; i < n; i++) begin
                        if (sh_slot_mode[i] != M_READY && sh_slot_mode[i] != M_SUSP) continue;
                        pk = sh_slot_parked[i];
                        if (pk && !parked_can_go(i[3:0])) begin
                            pend = 1;
                            continue;
                        end
                        if (best == NSLOT || (bpark && !pk) ||
                                (bpark == pk && sh_slot_prio[i] < bprio)) begin
                            best = i;
                            bprio = sh_slot_prio[i];
                            bpark = pk;
                        end
                    end
                    if (best == NSLOT) r.status = pend ? ST_PENDING : ST_NOTRUN;
                    else begin
                        launch_task(best[3:0]);
                        r.slot_out = best[3:0];
                    end
                end
            end
            F_RESUME_ID: begin
                if (sh_run_valid || c.slot_id >= n || (sh_slot_mode[c.slot_id] != M_READY &&
                        sh_slot_mode[c.slot_id] != M_SUSP)) begin
                    r.status = ST_NOTRUN;
                end else if (sh_slot_parked[c.slot_id] && !parked_can_go(c.slot_id)) begin
                    r.status = ST_PENDING;
                end else begin
                    launch_task(c.slot_id);
                    r.slot_out = c.slot_id;
                end
            end
            F_YIELD: begin
                if (!sh_run_valid) r.status = ST_NOTRUN;
                else begin
                    sh_slot_mode[rs] = M_SUSP;
                    sh_run_valid = 0;
                    r.slot_out = rs;
                end
            end
            F_FINISH: begin
                if (!sh_run_valid) r.status = ST_NOTRUN;
                else begin
                    // an owner leaving with its group still open releases the members
                    g = owned_grp(rs, M_READY);
                    if (g < NGROUP) begin
                        for (i = 0; i < NSLOT; i++)
                            if (sh_grp_members[g][i]) sh_slot_linked[i] = 0;
                        sh_grp_mode[g] = M_IDLE;
                        sh_grp_members[g] = '0;
                        sh_grp_finished[g] = '0;
                    end
                    if (sh_slot_linked[rs]) begin
                        g = sh_slot_grp[rs];
                        sh_grp_finished[g][rs] = 1'b1;
                        if (grp_is_done(g)) done_q_push(sh_grp_owner[g]);
                        sh_slot_linked[rs] = 0;
                    end
                    sh_slot_mode[rs] = M_IDLE;
                    sh_slot_parked[rs] = 0;
                    if (sh_task_cnt > 0) sh_task_cnt--;
                    sh_run_valid = 0;
                    r.slot_out = rs;
                end
            end
            F_GROUP_OPEN: begin
                if (!sh_run_valid) r.status = ST_NOTRUN;
                else if (owned_grp(rs, M_READY) < NGROUP) r.status = ST_BADGROUP;
                else begin
                    for (g = 0; g < NGROUP && sh_grp_mode[g] != M_IDLE; g++) ;
                    if (g >= NGROUP) r.status = ST_NOGROUP;
                    else begin
                        sh_grp_mode[g] = M_READY;
                        sh_grp_owner[g] = rs;
                        sh_grp_members[g] = '0;
                        sh_grp_finished[g] = '0;
                        r.group_out = g[1:0];
                    end
                end
            end
            F_GROUP_PARK: begin
                if (!sh_run_valid) r.status = ST_NOTRUN;
                else if (sh_grp_mode[c.group_id] != M_READY || sh_grp_owner[c.group_id] != rs)
                    r.status = ST_BADGROUP;
                else begin
                    sh_grp_mode[c.group_id] = M_RUN;
                    sh_slot_mode[rs] = M_SUSP;
                    sh_slot_parked[rs] = 1;
                    sh_run_valid = 0;
                    if (grp_is_done(c.group_id)) done_q_push(rs);
                    r.slot_out = rs;
                end
            end
            default: begin
                if (sh_run_valid || sh_done_fill == 0) r.status = ST_NOTRUN;
                else begin
                    q0 = sh_done_q[0];
                    if (sh_slot_mode[q0] != M_SUSP || !sh_slot_parked[q0] || !parked_can_go(q0)) begin
                        done_q_drop(q0);
                        r.status = ST_NOTRUN;
                    end else begin
                        launch_task(q0);
                        r.slot_out = q0;
                    end
                end
            end
        endcase
        for (i = 0; i < n; i++) begin
            if (sh_slot_mode[i] == M_IDLE) r.any_idle = 1'b1;
            else r.any_busy = 1'b1;
        end
        if (sh_run_valid) r.any_busy = 1'b1;
        r.active_tasks = sh_task_cnt[4:0];
        return r;
    endfunction

    function automatic t_cmd mk_cmd(input t_func f, input logic [31:0] p, input bit gv,
                                    input logic [1:0] gid, input logic [3:0] sid);
        t_cmd c;
        c.func = f;
        c.priority_req = p;
        c.group_valid = gv;
        c.group_id = gid;
        c.slot_id = sid;
        return c;
    endfunction

    // offer one event and record its outcome when the transaction completes
    task automatic send_event(input t_cmd c);
        t_res exp_res;
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data <= c;
        do @(posedge clk); while (!cmd_if.ready);
        exp_res = schedule_event(c);
        pending_results = {pending_results, exp_res};
        events_sent++;
    endtask

    task automatic stop_sending();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_slot_count(input logic [4:0] v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sh_slot_cfg = v;
        @(posedge clk);
    endtask

    // mostly well-formed scheduling traffic, some noise
    function automatic t_cmd random_event();
        t_cmd c;
        int sel, g;
        logic [31:0] p;
        c = '0;
        c.func = 3'($urandom_range(7));
        c.priority_req = $urandom;
        c.group_valid = 1'($urandom_range(1));
        c.group_id = 2'($urandom_range(3));
        c.slot_id = 4'($urandom_range(15));
        if ($urandom_range(99) < 10) return c;
        sel = $urandom_range(99);
        if (sel < 30) c.func = F_CREATE;
        else if (sel < 50) c.func = F_PICK;
        else if (sel < 64) c.func = F_FINISH;
        else if (sel < 71) c.func = F_YIELD;
        else if (sel < 78) c.func = F_RESUME_ID;
        else if (sel < 86) c.func = F_GROUP_OPEN;
        else if (sel < 93) c.func = F_GROUP_PARK;
        else c.func = F_RESUME_DONE;
        case ($urandom_range(3))
            0: p = 32'd0;
            1: p = 32'hFFFF_FFFF;
            2: p = $urandom_range(7);
            default: p = $urandom;
        endcase
        c.priority_req = p;
        g = sh_run_valid ? owned_grp(sh_run_slot, M_READY) : NGROUP;
        if (g < NGROUP && $urandom_range(99) < 85) begin
            c.group_id = g[1:0];
            c.group_valid = (c.func == F_CREATE) ? ($urandom_range(99) < 80) : c.group_valid;
        end else if (c.func == F_CREATE) begin
            c.group_valid = ($urandom_range(99) < 10);
        end
        if (c.func == F_RESUME_ID && $urandom_range(1)) begin
            for (int i = 0; i < NSLOT; i++)
                if (sh_slot_mode[i] == M_SUSP || sh_slot_mode[i] == M_READY) c.slot_id = i[3:0];
        end
        return c;
    endfunction

    task automatic test_directed();
        send_event(mk_cmd(F_PICK, 0, 0, 0, 0));
        send_event(mk_cmd(F_YIELD, 0, 0, 0, 0));
        send_event(mk_cmd(F_RESUME_DONE, 0, 0, 0, 0));
        send_event(mk_cmd(F_FINISH, 0, 0, 0, 0));
        send_event(mk_cmd(F_CREATE, 32'hFFFF_FFFF, 0, 0, 0));
        send_event(mk_cmd(F_CREATE, 32'd0, 0, 0, 0));
        send_event(mk_cmd(F_CREATE, 32'd3, 1, 2'd3, 0));
        send_event(mk_cmd(F_PICK, 0, 0, 0, 0));
        send_event(mk_cmd(F_GROUP_OPEN, 0, 0, 0, 0));
        send_event(mk_cmd(F_GROUP_OPEN, 0, 0, 0, 0));
        send_event(mk_cmd(F_CREATE, 32'd5, 1, 2'd0, 0));
        send_event(mk_cmd(F_CREATE, 32'd7, 1, 2'd0, 0));
        send_event(mk_cmd(F_GROUP_PARK, 0, 0, 2'd2, 0));
        send_event(mk_cmd(F_GROUP_PARK, 0, 0, 2'd0, 0));
        send_event(mk_cmd(F_RESUME_ID, 0, 0, 0, 4'd1));
        send_event(mk_cmd(F_RESUME_ID, 0, 0, 0, 4'd15));
        send_event(mk_cmd(F_PICK, 0, 0, 0, 0));
        send_event(mk_cmd(F_FINISH, 0, 0, 0, 0));
        send_event(mk_cmd(F_PICK, 0, 0, 0, 0));
        send_event(mk_cmd(F_FINISH, 0, 0, 0, 0));
        send_event(mk_cmd(F_RESUME_DONE, 0, 0, 0, 0));
        send_event(mk_cmd(F_GROUP_OPEN, 0, 0, 0, 0));
        send_event(mk_cmd(F_CREATE, 32'd1, 1, 2'd0, 0));
        send_event(mk_cmd(F_FINISH, 0, 0, 0, 0));
        send_event(mk_cmd(F_PICK, 0, 0, 0, 0));
        stop_sending();
    endtask

    task automatic test_small_table();
        write_slot_count(5'd1);
        send_event(mk_cmd(F_CREATE, 32'd9, 0, 0, 0));
        send_event(mk_cmd(F_CREATE, 32'd9, 0, 0, 0));
        send_event(mk_cmd(F_RESUME_ID, 0, 0, 0, 4'd1));
        stop_sending();
    endtask

    task automatic test_random(input logic [4:0] cnt, input int idle_pct,
                               input int stall_pct, input int items);
        write_slot_count(cnt);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) send_event(random_event());
        stop_sending();
    endtask

    // results held back long enough for the input side to stall
    task automatic test_backpressure();
        write_slot_count(5'd16);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        repeat (20) send_event(random_event());
        stop_sending();
        drain_results();
    endtask

    // result checking
    always @(posedge clk) begin
        t_res exp_r, act_r;
        if (rst_n && res_if.valid && res_if.ready) begin
            act_r = res_if.data;
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, act_r);
                errors++;
            end else begin
                exp_r = pending_results[0];
                pending_results.delete(0);
                if (act_r !== exp_r) begin
                    $display("%0t: result mismatch expected %p actual %p", $time, exp_r, act_r);
                    errors++;
                end
            end
        end
    end

    // receiver stalls, with a long hold-off counted here
    always @(posedge clk) begin
        if (hold_start) hold_left = HOLD_LEN;
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || !rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
                $display("** task_slot_priority_scheduler_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        events_sent = 0;
        results_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        shadow_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_small_table();
        test_random(5'd16, 0, 0, 150);
        test_random(5'd5, 69, 0, 120);
        test_random(5'd1, 0, 69, 80);
        test_random(5'd31, 30, 30, 150);
        test_random(5'd0, 30, 30, 40);
        test_backpressure();
        test_random(5'd8, 0, 0, 120);
        drain_results();

        $display("ran %0d scheduling events, %0d results checked, %0d errors",
                 events_sent, results_seen, errors);
        $display("slot counts 0 to 31, idle and stall mixes, long result hold-off");
        if (errors == 0)
            $display("** task_slot_priority_scheduler_unit: PASSED **");
        else
            $display("** task_slot_priority_scheduler_unit: FAILED **");
        $finish;
    end
endmodule
